FILE: rtl/core/sced_pkg.sv
// ============================================================================
// sced_pkg: shared types and constants
// Field widths, register indexes, direction codes and the result record of
// the cumulative seam energy block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package sced_pkg;

  localparam int GRAY_W     = 8;
  localparam int BAL_W      = 8;
  localparam int ENERGY_W   = 24;
  localparam int SUM_W      = ENERGY_W + 2;
  localparam int DIR_W      = 2;
  localparam int COORD_W    = 10;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST = 11'd1024;

  localparam logic signed [DIR_W-1:0] DIR_LEFT  = -2'sd1;
  localparam logic signed [DIR_W-1:0] DIR_UP    = 2'sd0;
  localparam logic signed [DIR_W-1:0] DIR_RIGHT = 2'sd1;

  // Result queue sizing
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [ENERGY_W-1:0]     cumulative_energy;
    logic signed [DIR_W-1:0] parent_direction;
    logic [COORD_W-1:0]      pixel_column;
    logic [COORD_W-1:0]      pixel_row;
    logic                    last_of_run;
  } result_t;

  // Which cost rule applies to one pixel
  typedef struct packed {
    logic row0;
    logic left;
    logic right;
  } cost_mode_t;

endpackage

`default_nettype wire

FILE: rtl/core/sced_if.sv
// ============================================================================
// sced_if: channel interfaces
// Pixel input, result output and configuration write channels, each with
// valid/ready and a source and a sink modport.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface sced_pixel_if;
  import sced_pkg::*;
  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] gray_pixel;
  logic [BAL_W-1:0]  balance_energy;

  modport source (output valid, output gray_pixel, output balance_energy, input ready);
  modport sink   (input valid, input gray_pixel, input balance_energy, output ready);
endinterface

interface sced_result_if;
  import sced_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ENERGY_W-1:0]     cumulative_energy;
  logic signed [DIR_W-1:0] parent_direction;
  logic [COORD_W-1:0]      pixel_column;
  logic [COORD_W-1:0]      pixel_row;
  logic                    last_of_run;

  modport source (output valid, output cumulative_energy, output parent_direction,
                  output pixel_column, output pixel_row, output last_of_run,
                  input ready);
  modport sink   (input valid, input cumulative_energy, input parent_direction,
                  input pixel_column, input pixel_row, input last_of_run,
                  output ready);
endinterface

interface sced_cfg_if;
  import sced_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sced_line_store.sv
// ============================================================================
// sced_line_store: previous-row line memories
// Gray and cumulative energy of the row above, one entry per column. Reads
// are registered; an energy write to the address being read is forwarded.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sced_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [AW-1:0]                addr_i,
  input  logic [sced_pkg::GRAY_W-1:0]  gray_wdata_i,
  output logic [sced_pkg::GRAY_W-1:0]  gray_rdata_o,
  input  logic                         energy_we_i,
  input  logic [AW-1:0]                energy_waddr_i,
  input  logic [sced_pkg::ENERGY_W-1:0] energy_wdata_i,
  output logic [sced_pkg::ENERGY_W-1:0] energy_rdata_o
);
  import sced_pkg::*;

  logic [GRAY_W-1:0]   gray_mem [DEPTH];
  logic [ENERGY_W-1:0] energy_mem [DEPTH];
  logic [GRAY_W-1:0]   gray_rd_q;
  logic [ENERGY_W-1:0] energy_rd_q;

  // Read the old row and overwrite with the new pixel at the same column
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      gray_rd_q          <= gray_mem[addr_i];
      gray_mem[addr_i]   <= gray_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (energy_we_i) begin
      energy_mem[energy_waddr_i] <= energy_wdata_i;
    end
    if (rd_en_i) begin
      if (energy_we_i && (energy_waddr_i == addr_i)) begin
        energy_rd_q <= energy_wdata_i;
      end else begin
        energy_rd_q <= energy_mem[addr_i];
      end
    end
  end

  assign gray_rdata_o   = gray_rd_q;
  assign energy_rdata_o = energy_rd_q;

endmodule

`default_nettype wire

FILE: rtl/core/sced_cost.sv
// ============================================================================
// sced_cost: per-pixel energy evaluation
// Row-0 gradient, edge-column inheritance or forward-cost minimum over the
// three parents, with saturating sums.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sced_cost (
  input  sced_pkg::cost_mode_t          mode_i,
  input  logic [sced_pkg::GRAY_W-1:0]   d_i,
  input  logic [sced_pkg::GRAY_W-1:0]   e_i,
  input  logic [sced_pkg::GRAY_W-1:0]   f_i,
  input  logic [sced_pkg::BAL_W-1:0]    bal_i,
  input  logic [sced_pkg::BAL_W-1:0]    edge_bal_left_i,
  input  logic [sced_pkg::BAL_W-1:0]    edge_bal_right_i,
  input  logic [sced_pkg::ENERGY_W-1:0] up_energy_l_i,
  input  logic [sced_pkg::ENERGY_W-1:0] up_energy_c_i,
  input  logic [sced_pkg::ENERGY_W-1:0] up_energy_r_i,
  input  logic [sced_pkg::GRAY_W-1:0]   up_gray_l_i,
  input  logic [sced_pkg::GRAY_W-1:0]   up_gray_c_i,
  input  logic [sced_pkg::GRAY_W-1:0]   up_gray_r_i,
  output logic [sced_pkg::ENERGY_W-1:0] energy_o,
  output logic signed [sced_pkg::DIR_W-1:0] dir_o
);
  import sced_pkg::*;

  function automatic logic [GRAY_W-1:0] adiff(input logic [GRAY_W-1:0] x,
                                                input logic [GRAY_W-1:0] y);
    return (x > y) ? (x - y) : (y - x);
  endfunction

  function automatic logic [ENERGY_W-1:0] sat(input logic [SUM_W-1:0] s);
    return (s > SUM_W'(ENERGY_MAX)) ? ENERGY_MAX : s[ENERGY_W-1:0];
  endfunction

  logic [GRAY_W-1:0]       row0_grad;
  logic [ENERGY_W-1:0]     row0_energy;
  logic [GRAY_W-1:0]       edge_grad;
  logic [BAL_W-1:0]        edge_bal;
  logic [ENERGY_W-1:0]     edge_energy;
  logic [GRAY_W-1:0]       ad, bd, be, cf, bf;
  logic [GRAY_W:0]         sva, svc, she;
  logic [ENERGY_W-1:0]     cand_l, cand_r, best;
  logic signed [DIR_W-1:0] best_dir;
  logic [ENERGY_W-1:0]     inner_energy;

  // Row 0: balance plus horizontal gradient, pixel stands in at the edges
  assign row0_grad   = mode_i.left  ? adiff(e_i, f_i) :
                       mode_i.right ? adiff(d_i, e_i) : adiff(d_i, f_i);
  assign row0_energy = ENERGY_W'((GRAY_W + 1)'(bal_i) + (GRAY_W + 1)'(row0_grad));

  // Edge columns: inherit straight down
  assign edge_grad   = mode_i.left ? adiff(e_i, f_i) : adiff(e_i, d_i);
  assign edge_bal    = mode_i.left ? edge_bal_left_i : edge_bal_right_i;
  assign edge_energy = sat(SUM_W'(up_energy_c_i) + SUM_W'(edge_bal)
                           + SUM_W'({edge_grad, 1'b0}));

  // Inner pixels: forward costs
  assign ad  = adiff(up_gray_l_i, d_i);
  assign bd  = adiff(up_gray_c_i, d_i);
  assign be  = adiff(up_gray_c_i, e_i);
  assign cf  = adiff(up_gray_r_i, f_i);
  assign bf  = adiff(up_gray_c_i, f_i);
  assign sva = (GRAY_W + 1)'(adiff(ad, bd)) + (GRAY_W + 1)'(adiff(be, bd));
  assign svc = (GRAY_W + 1)'(adiff(cf, bf)) + (GRAY_W + 1)'(adiff(be, bf));
  assign she = (GRAY_W + 1)'(adiff(d_i, e_i)) + (GRAY_W + 1)'(adiff(e_i, f_i))
               - (GRAY_W + 1)'(adiff(d_i, f_i));

  assign cand_l = sat(SUM_W'(up_energy_l_i) + SUM_W'(sva));
  assign cand_r = sat(SUM_W'(up_energy_r_i) + SUM_W'(svc));

  // Up first; a side wins only when strictly smaller
  always_comb begin
    best     = up_energy_c_i;
    best_dir = DIR_UP;
    if (cand_l < best) begin
      best     = cand_l;
      best_dir = DIR_LEFT;
    end
    if (cand_r < best) begin
      best     = cand_r;
      best_dir = DIR_RIGHT;
    end
  end

  assign inner_energy = sat(SUM_W'(best) + SUM_W'(she) + SUM_W'(bal_i));

  always_comb begin
    if (mode_i.row0) begin
      energy_o = row0_energy;
      dir_o    = DIR_UP;
    end else if (mode_i.left || mode_i.right) begin
      energy_o = edge_energy;
      dir_o    = DIR_UP;
    end else begin
      energy_o = inner_energy;
      dir_o    = best_dir;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sced_out_queue.sv
// ============================================================================
// sced_out_queue: result queue
// Small FIFO between the compute stage and the result channel; takes up to
// two results per cycle and hands out one.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sced_out_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        push_cnt_i,
  input  sced_pkg::result_t                 push_data0_i,
  input  sced_pkg::result_t                 push_data1_i,
  input  logic                              pop_i,
  output logic                              valid_o,
  output sced_pkg::result_t                 head_o,
  output logic [sced_pkg::OQ_CNT_W-1:0]     space_o
);
  import sced_pkg::*;

  result_t               ent_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OQ_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OQ_CNT_W-1:0]   count_q, count_d;
  logic                  do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign valid_o = (count_q != '0);
  assign head_o  = ent_q[rd_ptr_q];
  assign space_o = OQ_CNT_W'(OQ_DEPTH) - count_q;

  assign wr_ptr_d = wr_ptr_q + OQ_PTR_W'(push_cnt_i);
  assign rd_ptr_d = rd_ptr_q + OQ_PTR_W'(do_pop);
  assign count_d  = count_q + OQ_CNT_W'(push_cnt_i) - OQ_CNT_W'(do_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      ent_q[wr_ptr_q] <= push_data0_i;
    end
    if (push_cnt_i == 2'd2) begin
      ent_q[wr_ptr_q + OQ_PTR_W'(1)] <= push_data1_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/seam_cumulative_energy_dp.sv
// ============================================================================
// seam_cumulative_energy_dp: cumulative vertical seam energy
// Raster-order pixel stream in, minimum cumulative energy and parent
// direction per pixel out, with line memories for the row above.
// ============================================================================
// Usage:
//   pix_i   carries gray_pixel and balance_energy, one transaction per pixel,
//           raster order. cfg_i writes image_width (index 0) and image_height
//           (index 1); write them only while the block is idle.
//   res_o   carries one result per pixel. A result needs its right neighbor,
//           so the first pixel of a row gives no result and the last pixel
//           gives two (left neighbor, then itself); last_of_run marks the
//           final result caused by one input transaction.
// Flow: an accepted pixel enters the compute stage, its results go to the
//   result queue once they fit there, and they leave the block from the
//   queue registers.
// Throughput: one pixel per cycle while res_o.ready stays high. The rate is
//   set by the single line memory read per pixel (column x of the row above)
//   and by the result channel, which moves one result per cycle; a row end
//   pushes two results and the next column-0 pixel pushes none, and the
//   four-entry result queue evens this out.
// Reset: row and column restart at zero, both sizes return to 1024. The line
//   memories are not cleared; row 0 does not use what they return.
// Stall: while res_o.ready is low the queue fills; the compute stage holds a
//   pixel until its results fit, and pix_i.ready drops only then.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module seam_cumulative_energy_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  sced_pixel_if.sink     pix_i,
  sced_result_if.source  res_o,
  sced_cfg_if.sink       cfg_i
);
  import sced_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] width_q;
  logic [CFG_DATA_W-1:0] height_q;
  logic [ColW-1:0]       last_col;
  logic [RowW-1:0]       last_row;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= IMAGE_WIDTH_RST;
      height_q <= IMAGE_HEIGHT_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_IMAGE_WIDTH:  width_q  <= cfg_i.data;
        REG_IMAGE_HEIGHT: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Clamp sizes to the supported range, keep the last index of each
  always_comb begin
    if (width_q < CFG_DATA_W'(2)) begin
      last_col = ColW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      last_col = ColW'(MAX_WIDTH - 1);
    end else begin
      last_col = ColW'(width_q - CFG_DATA_W'(1));
    end
  end

  always_comb begin
    if (height_q == '0) begin
      last_row = '0;
    end else if (32'(height_q) > MAX_HEIGHT) begin
      last_row = RowW'(MAX_HEIGHT - 1);
    end else begin
      last_row = RowW'(height_q - CFG_DATA_W'(1));
    end
  end

  // --------------------------------------------------------------------------
  // Input stage: position counters and line memory read
  // --------------------------------------------------------------------------
  logic            pix_acc;
  logic            at_row_end;
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;

  logic              s1_valid_q;
  logic              s1_first_q;
  logic              s1_end_q;
  logic [ColW-1:0]   s1_col_q;
  logic [RowW-1:0]   s1_row_q;
  logic [GRAY_W-1:0] s1_gray_q;
  logic [BAL_W-1:0]  s1_bal_q;
  logic              fire;

  assign pix_acc    = pix_i.valid && pix_i.ready;
  assign at_row_end = (col_q >= last_col);
  assign pix_i.ready = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_first_q <= 1'b0;
      s1_end_q   <= 1'b0;
    end else begin
      if (pix_acc) begin
        s1_valid_q <= 1'b1;
        s1_first_q <= (col_q == '0);
        s1_end_q   <= at_row_end;
        if (at_row_end) begin
          col_q <= '0;
          row_q <= (row_q >= last_row) ? '0 : row_q + RowW'(1);
        end else begin
          col_q <= col_q + ColW'(1);
        end
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_gray_q <= pix_i.gray_pixel;
      s1_bal_q  <= pix_i.balance_energy;
    end
  end

  // --------------------------------------------------------------------------
  // Line memories
  // --------------------------------------------------------------------------
  logic [GRAY_W-1:0]   up_gray_rd;
  logic [ENERGY_W-1:0] up_energy_rd;
  logic                energy_we;
  logic [ColW-1:0]     energy_waddr;
  logic [ENERGY_W-1:0] energy_wdata;

  sced_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (ColW)
  ) u_line_store (
    .clk_i          (clk_i),
    .rd_en_i        (pix_acc),
    .addr_i         (col_q),
    .gray_wdata_i   (pix_i.gray_pixel),
    .gray_rdata_o   (up_gray_rd),
    .energy_we_i    (energy_we),
    .energy_waddr_i (energy_waddr),
    .energy_wdata_i (energy_wdata),
    .energy_rdata_o (up_energy_rd)
  );

  // --------------------------------------------------------------------------
  // Compute stage
  // --------------------------------------------------------------------------
  // Window over the row above: columns x-2, x-1 in registers, x from memory
  logic [ENERGY_W-1:0] win_e0_q, win_e1_q;
  logic [GRAY_W-1:0]   win_g0_q, win_g1_q;
  // Current row: gray at x-2 and x-1, balance at x-1, edge balances above
  logic [GRAY_W-1:0]   hold0_q, hold1_q;
  logic [BAL_W-1:0]    bhold1_q;
  logic [BAL_W-1:0]    ebal0_q, ebal1_q;
  // Energy of the last column, written in the cycle after the row end
  logic                pend_valid_q;
  logic [ColW-1:0]     pend_addr_q;
  logic [ENERGY_W-1:0] pend_data_q;

  logic [1:0]              need;
  logic [OQ_CNT_W-1:0]     oq_space;
  cost_mode_t              main_mode, edge_mode;
  logic [ENERGY_W-1:0]     main_energy, edge_energy;
  logic signed [DIR_W-1:0] main_dir, edge_dir;
  result_t                 res_main, res_edge, res_head;
  logic                    res_valid;

  // Results caused by this pixel: none at column 0, two at the row end
  assign need = s1_first_q ? 2'd0 : (s1_end_q ? 2'd2 : 2'd1);
  assign fire = s1_valid_q && (OQ_CNT_W'(need) <= oq_space);

  assign main_mode = '{row0: (s1_row_q == '0), left: (s1_col_q == ColW'(1)), right: 1'b0};
  assign edge_mode = '{row0: (s1_row_q == '0), left: 1'b0, right: 1'b1};

  // Pixel x-1
  sced_cost u_cost_main (
    .mode_i           (main_mode),
    .d_i              (hold0_q),
    .e_i              (hold1_q),
    .f_i              (s1_gray_q),
    .bal_i            (bhold1_q),
    .edge_bal_left_i  (ebal0_q),
    .edge_bal_right_i (ebal1_q),
    .up_energy_l_i    (win_e0_q),
    .up_energy_c_i    (win_e1_q),
    .up_energy_r_i    (up_energy_rd),
    .up_gray_l_i      (win_g0_q),
    .up_gray_c_i      (win_g1_q),
    .up_gray_r_i      (up_gray_rd),
    .energy_o         (main_energy),
    .dir_o            (main_dir)
  );

  // Pixel x at the row end
  sced_cost u_cost_edge (
    .mode_i           (edge_mode),
    .d_i              (hold1_q),
    .e_i              (s1_gray_q),
    .f_i              ('0),
    .bal_i            (s1_bal_q),
    .edge_bal_left_i  (ebal0_q),
    .edge_bal_right_i (ebal1_q),
    .up_energy_l_i    (win_e1_q),
    .up_energy_c_i    (up_energy_rd),
    .up_energy_r_i    (up_energy_rd),
    .up_gray_l_i      (win_g1_q),
    .up_gray_c_i      (up_gray_rd),
    .up_gray_r_i      (up_gray_rd),
    .energy_o         (edge_energy),
    .dir_o            (edge_dir)
  );

  assign res_main = '{
    cumulative_energy: main_energy,
    parent_direction:  main_dir,
    pixel_column:      COORD_W'(s1_col_q - ColW'(1)),
    pixel_row:         COORD_W'(s1_row_q),
    last_of_run:       !s1_end_q
  };
  assign res_edge = '{
    cumulative_energy: edge_energy,
    parent_direction:  edge_dir,
    pixel_column:      COORD_W'(s1_col_q),
    pixel_row:         COORD_W'(s1_row_q),
    last_of_run:       1'b1
  };

  // Write back energy of pixel x-1; the last column follows next cycle, when
  // the stage holds at most a column-0 pixel that writes nothing
  always_comb begin
    energy_we    = 1'b0;
    energy_waddr = pend_addr_q;
    energy_wdata = pend_data_q;
    if (fire && !s1_first_q) begin
      energy_we    = 1'b1;
      energy_waddr = s1_col_q - ColW'(1);
      energy_wdata = main_energy;
    end else if (pend_valid_q) begin
      energy_we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      hold0_q      <= '0;
      hold1_q      <= '0;
      bhold1_q     <= '0;
      ebal0_q      <= '0;
      ebal1_q      <= '0;
    end else begin
      pend_valid_q <= fire && s1_end_q;
      if (fire) begin
        if (!s1_first_q) begin
          hold0_q <= hold1_q;
        end
        hold1_q  <= s1_gray_q;
        bhold1_q <= s1_bal_q;
        if (main_mode.left && !s1_first_q) begin
          ebal0_q <= bhold1_q;
        end
        if (s1_end_q) begin
          ebal1_q <= s1_bal_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      win_e0_q <= win_e1_q;
      win_e1_q <= up_energy_rd;
      win_g0_q <= win_g1_q;
      win_g1_q <= up_gray_rd;
    end
    if (fire && s1_end_q) begin
      pend_addr_q <= s1_col_q;
      pend_data_q <= edge_energy;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue and output channel
  // --------------------------------------------------------------------------
  sced_out_queue u_out_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cnt_i   (fire ? need : 2'd0),
    .push_data0_i (res_main),
    .push_data1_i (res_edge),
    .pop_i        (res_o.ready),
    .valid_o      (res_valid),
    .head_o       (res_head),
    .space_o      (oq_space)
  );

  assign res_o.valid             = res_valid;
  assign res_o.cumulative_energy = res_head.cumulative_energy;
  assign res_o.parent_direction  = res_head.parent_direction;
  assign res_o.pixel_column      = res_head.pixel_column;
  assign res_o.pixel_row         = res_head.pixel_row;
  assign res_o.last_of_run       = res_head.last_of_run;

endmodule

`default_nettype wire

FILE: rtl/core/sced_checker.sv
// ============================================================================
// sced_checker: port-level checks
// Watches the result channel of the cumulative seam energy block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sced_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              res_valid_i,
  input logic                              res_ready_i,
  input logic [sced_pkg::ENERGY_W-1:0]     res_energy_i,
  input logic signed [sced_pkg::DIR_W-1:0] res_dir_i,
  input logic [sced_pkg::COORD_W-1:0]      res_column_i,
  input logic [sced_pkg::COORD_W-1:0]      res_row_i,
  input logic                              res_last_i
);
  import sced_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_energy_i)
      && $stable(res_dir_i) && $stable(res_column_i) && $stable(res_row_i)
      && $stable(res_last_i))
    else $error("stalled result changed");

  // A row-end pair is queued together: the second result is there at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && !res_last_i |=> res_valid_i && res_last_i)
    else $error("second result of a row end missing");

  // The second result of a pair is the right neighbor on the same row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && !res_last_i |=>
      (res_column_i == $past(res_column_i) + COORD_W'(1))
      && (res_row_i == $past(res_row_i)))
    else $error("row-end pair not adjacent");

endmodule

bind seam_cumulative_energy_dp sced_checker u_sced_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_energy_i (res_o.cumulative_energy),
  .res_dir_i    (res_o.parent_direction),
  .res_column_i (res_o.pixel_column),
  .res_row_i    (res_o.pixel_row),
  .res_last_i   (res_o.last_of_run)
);

`default_nettype wire
